// ----- rtl/bus_mapped_serial_mul_div_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bus-mapped multiply/divide unit
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef BUS_MAPPED_SERIAL_MUL_DIV_UNIT_DEFINES_SVH
`define BUS_MAPPED_SERIAL_MUL_DIV_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BMMDU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define BMMDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bmmdu_pkg.sv -----
// ----------------------------------------------------------------------------
// bmmdu_pkg
// Register map, request codes and step counts of the multiply/divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmmdu_pkg;

   // Request kinds carried on req_type
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   // Operand registers (write side)
   localparam logic [15:0] ADDR_MUL_A   = 16'h4202;
   localparam logic [15:0] ADDR_MUL_B   = 16'h4203;
   localparam logic [15:0] ADDR_DIVD_LO = 16'h4204;
   localparam logic [15:0] ADDR_DIVD_HI = 16'h4205;
   localparam logic [15:0] ADDR_DIVISOR = 16'h4206;

   // Result registers (read side)
   localparam logic [15:0] ADDR_QUOT_LO = 16'h4214;
   localparam logic [15:0] ADDR_QUOT_HI = 16'h4215;
   localparam logic [15:0] ADDR_PROD_LO = 16'h4216;
   localparam logic [15:0] ADDR_PROD_HI = 16'h4217;

   // Step counts of one operation
   localparam logic [3:0] MUL_STEPS = 4'd8;
   localparam logic [4:0] DIV_STEPS = 5'd16;

endpackage

// ----- rtl/bus_mapped_serial_mul_div_unit.sv -----
// ----------------------------------------------------------------------------
// bus_mapped_serial_mul_div_unit
// Register-mapped 8x8 shift-add multiplier and 16/8 restoring divider.
// ----------------------------------------------------------------------------
// Each request beat (tick, register read or register write) produces exactly
// one response beat, registered and presented in the next cycle; with the
// response side ready, a new request is taken every cycle. The response
// register sits between the two sides, so a request is still taken while the
// previous response waits, as long as that response is taken in the same
// cycle. A multiply needs 8 tick beats and a divide 16 tick beats after the
// start write; one tick beat advances the running operation by one step, set
// by a single 16-bit add (multiply) or 24-bit compare, 16-bit subtract (divide).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bus_mapped_serial_mul_div_unit_defines.svh"

module bus_mapped_serial_mul_div_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_busy_res,
   output logic        rsp_bad_address
);

   // architectural state
   logic [7:0]  mcand_low_ff, mcand_low_in;
   logic [15:0] dividend_ff,  dividend_in;
   logic [15:0] quot_ff,      quot_in;
   logic [15:0] prod_ff,      prod_in;
   logic [23:0] shop_ff,      shop_in;
   logic [3:0]  mul_left_ff,  mul_left_in;
   logic [4:0]  div_left_ff,  div_left_in;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  rd_ff, rd_in;
   logic        busy_ff;
   logic        bad_ff, bad_in;

   // one step of each operation
   logic [15:0] mul_quot, div_quot;
   logic [15:0] mul_prod, div_prod;
   logic [23:0] mul_shop, div_shop;
   logic        idle_now;
   logic        req_fire;
   bmmdu_pkg::req_kind_type req_kind;

   assign req_fire  = req_valid & req_ready;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign idle_now  = (mul_left_ff == 4'd0) && (div_left_ff == 5'd0);
   assign req_kind  = bmmdu_pkg::req_kind_type'(req_type);

   // multiply step: conditional add, then shift operand left and multiplier right
   always_comb begin
      mul_prod = quot_ff[0] ? (prod_ff + shop_ff[15:0]) : prod_ff;
      mul_shop = {shop_ff[22:0], 1'b0};
      mul_quot = {1'b0, quot_ff[15:1]};
   end

   // divide step: shift divisor right, try subtract, shift in quotient bit
   always_comb begin
      div_shop = {1'b0, shop_ff[23:1]};
      if ({8'd0, prod_ff} >= div_shop) begin
         div_prod = prod_ff - div_shop[15:0];
         div_quot = {quot_ff[14:0], 1'b1};
      end else begin
         div_prod = prod_ff;
         div_quot = {quot_ff[14:0], 1'b0};
      end
   end

   // decode the beat and form next state and response
   always_comb begin
      mcand_low_in = mcand_low_ff;
      dividend_in  = dividend_ff;
      quot_in      = quot_ff;
      prod_in      = prod_ff;
      shop_in      = shop_ff;
      mul_left_in  = mul_left_ff;
      div_left_in  = div_left_ff;
      rd_in        = 8'd0;
      bad_in       = 1'b0;
      case (req_kind)
         bmmdu_pkg::REQ_TICK: begin
            if (mul_left_ff != 4'd0) begin
               mul_left_in = mul_left_ff - 4'd1;
               prod_in     = mul_prod;
               shop_in     = mul_shop;
               quot_in     = mul_quot;
            end else if (div_left_ff != 5'd0) begin
               div_left_in = div_left_ff - 5'd1;
               prod_in     = div_prod;
               shop_in     = div_shop;
               quot_in     = div_quot;
            end
         end
         bmmdu_pkg::REQ_READ: begin
            unique case (req_address)
               bmmdu_pkg::ADDR_QUOT_LO: rd_in = quot_ff[7:0];
               bmmdu_pkg::ADDR_QUOT_HI: rd_in = quot_ff[15:8];
               bmmdu_pkg::ADDR_PROD_LO: rd_in = prod_ff[7:0];
               bmmdu_pkg::ADDR_PROD_HI: rd_in = prod_ff[15:8];
               default:                 bad_in = 1'b1;
            endcase
         end
         bmmdu_pkg::REQ_WRITE: begin
            unique case (req_address)
               bmmdu_pkg::ADDR_MUL_A: mcand_low_in = req_write_data;
               bmmdu_pkg::ADDR_MUL_B: begin
                  prod_in = 16'd0;
                  if (idle_now) begin
                     mul_left_in = bmmdu_pkg::MUL_STEPS;
                     quot_in     = {req_write_data, mcand_low_ff};
                     shop_in     = {16'd0, req_write_data};
                  end
               end
               bmmdu_pkg::ADDR_DIVD_LO: dividend_in = {dividend_ff[15:8], req_write_data};
               bmmdu_pkg::ADDR_DIVD_HI: dividend_in = {req_write_data, dividend_ff[7:0]};
               bmmdu_pkg::ADDR_DIVISOR: begin
                  prod_in = dividend_ff;
                  if (idle_now) begin
                     div_left_in = bmmdu_pkg::DIV_STEPS;
                     shop_in     = {req_write_data, 16'd0};
                  end
               end
               default: bad_in = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   // update state on an accepted request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mcand_low_ff <= 8'd0;
         dividend_ff  <= 16'd0;
         quot_ff      <= 16'd0;
         prod_ff      <= 16'd0;
         shop_ff      <= 24'd0;
         mul_left_ff  <= 4'd0;
         div_left_ff  <= 5'd0;
      end else if (req_fire) begin
         mcand_low_ff <= mcand_low_in;
         dividend_ff  <= dividend_in;
         quot_ff      <= quot_in;
         prod_ff      <= prod_in;
         shop_ff      <= shop_in;
         mul_left_ff  <= mul_left_in;
         div_left_ff  <= div_left_in;
      end
   end

   // hold the response valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // load the response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff   <= rd_in;
         busy_ff <= (mul_left_in != 4'd0) || (div_left_in != 5'd0);
         bad_ff  <= bad_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rd_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_bad_address = bad_ff;

   // checks
   `BMMDU_ASSERT_NOW(a_one_op, clock, reset, 1'b1, (mul_left_ff == 4'd0) || (div_left_ff == 5'd0), "multiply and divide running together")
   `BMMDU_ASSERT_NOW(a_step_range, clock, reset, 1'b1, (mul_left_ff <= bmmdu_pkg::MUL_STEPS) && (div_left_ff <= bmmdu_pkg::DIV_STEPS), "step counter out of range")
   `BMMDU_ASSERT_NEXT(a_tick_step, clock, reset, req_fire && (req_kind == bmmdu_pkg::REQ_TICK) && (mul_left_ff != 4'd0), mul_left_ff == $past(mul_left_ff) - 4'd1, "tick did not advance multiply")
   `BMMDU_ASSERT_NEXT(a_busy_flag, clock, reset, req_fire, rsp_busy_res == ((mul_left_ff != 4'd0) || (div_left_ff != 5'd0)), "busy flag disagrees with step counters")
   `BMMDU_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid_ff && bad_ff, rd_ff == 8'd0, "bad address beat carries read data")

endmodule

// ----- test/mul_div_check_pkg.sv -----
// ----------------------------------------------------------------------------
// mul_div_check_pkg
// Scoreboard for the bus-mapped multiply/divide unit. It keeps its own copy
// of the operand, shift and step registers, works out the reply beat of
// every accepted request and checks the replies against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mul_div_check_pkg;

   import bmmdu_pkg::*;

   typedef struct packed {
      logic [7:0] read_data;
      logic       busy_res;
      logic       bad_address;
   } reply_beat_t;

   class mul_div_scoreboard;
      logic [7:0]  mcand_lo;
      logic [15:0] dividend;
      logic [15:0] quotient;
      logic [15:0] prod_rem;
      logic [23:0] operand;
      logic [3:0]  mul_left;
      logic [4:0]  div_left;
      reply_beat_t expected_replies[$];
      int          mismatches;

      function new();
         mcand_lo   = '0;
         dividend   = '0;
         quotient   = '0;
         prod_rem   = '0;
         operand    = '0;
         mul_left   = '0;
         div_left   = '0;
         mismatches = 0;
      endfunction

      function bit engine_idle();
         return (mul_left == 0) && (div_left == 0);
      endfunction

      // Advance a running multiply or divide by one step
      function void step_engine();
         if (mul_left != 0) begin
            mul_left = mul_left - 1'b1;
            if (quotient[0]) begin
               prod_rem = prod_rem + operand[15:0];
            end
            operand  = operand << 1;
            quotient = quotient >> 1;
         end
         if (div_left != 0) begin
            div_left = div_left - 1'b1;
            operand  = operand >> 1;
            quotient = quotient << 1;
            if ({8'h00, prod_rem} >= operand) begin
               prod_rem    = prod_rem - operand[15:0];
               quotient[0] = 1'b1;
            end
         end
      endfunction

      // Apply one accepted request beat and queue the reply it must cause
      function void note_request(logic [1:0] kind, logic [15:0] addr, logic [7:0] wdata);
         reply_beat_t beat;
         beat = '0;
         case (kind)
            REQ_TICK: begin
               step_engine();
            end
            REQ_READ: begin
               case (addr)
                  ADDR_QUOT_LO: beat.read_data = quotient[7:0];
                  ADDR_QUOT_HI: beat.read_data = quotient[15:8];
                  ADDR_PROD_LO: beat.read_data = prod_rem[7:0];
                  ADDR_PROD_HI: beat.read_data = prod_rem[15:8];
                  default:      beat.bad_address = 1'b1;
               endcase
            end
            REQ_WRITE: begin
               case (addr)
                  ADDR_MUL_A: mcand_lo = wdata;
                  ADDR_MUL_B: begin
                     prod_rem = '0;
                     if (engine_idle()) begin
                        mul_left = MUL_STEPS;
                        quotient = {wdata, mcand_lo};
                        operand  = {16'h0000, wdata};
                     end
                  end
                  ADDR_DIVD_LO: dividend[7:0]  = wdata;
                  ADDR_DIVD_HI: dividend[15:8] = wdata;
                  ADDR_DIVISOR: begin
                     prod_rem = dividend;
                     if (engine_idle()) begin
                        div_left = DIV_STEPS;
                        operand  = {wdata, 16'h0000};
                     end
                  end
                  default: beat.bad_address = 1'b1;
               endcase
            end
            default: ;
         endcase
         beat.busy_res = !engine_idle();
         expected_replies.push_back(beat);
      endfunction

      // Compare one reply beat with the oldest expectation
      function void check_reply(logic [7:0] rd, logic busy, logic bad);
         reply_beat_t want;
         if (expected_replies.size() == 0) begin
            $error("reply beat with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         if (rd !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, rd);
            mismatches++;
         end
         if (busy !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, busy);
            mismatches++;
         end
         if (bad !== want.bad_address) begin
            $error("bad_address: expected %0b, got %0b", want.bad_address, bad);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

endpackage

// ----- test/bus_mapped_serial_mul_div_unit_tb.sv -----
// ----------------------------------------------------------------------------
// bus_mapped_serial_mul_div_unit_tb
// Drives ticks, register reads and writes into the multiply/divide unit with
// random gaps and reply stalls, and checks every reply beat against the
// scoreboard: directed corner cases first, then random multiply and divide
// sequences mixed with stray accesses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_mapped_serial_mul_div_unit_tb;

   import bmmdu_pkg::*;
   import mul_div_check_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int ITEM_TARGET  = 1550;
   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES  = 240;
   localparam int DRAIN_CYCLES = 4;
   localparam int STALL_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [15:0] req_address;
   logic [7:0]  req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_data;
   logic        rsp_busy_res;
   logic        rsp_bad_address;

   mul_div_scoreboard sb;
   int items_sent;
   int send_calm;
   int recv_calm;
   int stall_cycles;
   bit hold_replies;

   bus_mapped_serial_mul_div_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_bad_address (rsp_bad_address)
   );

   always #10 clock = ~clock;

   // Idle cycles before a beat; now and then a calm stretch with no idling
   function automatic int draw_idle(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 40);
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] result_addr(int idx);
      case (idx)
         0:       return ADDR_QUOT_LO;
         1:       return ADDR_QUOT_HI;
         2:       return ADDR_PROD_LO;
         default: return ADDR_PROD_HI;
      endcase
   endfunction

   // Offer one request beat and hold it until it is taken
   task automatic send_beat(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] wdata);
      int gap;
      gap = draw_idle(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_address    <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_reg(input logic [15:0] addr, input logic [7:0] wdata);
      send_beat(REQ_WRITE, addr, wdata);
   endtask

   task automatic run_ticks(input int n);
      repeat (n) send_beat(REQ_TICK, 16'($urandom_range(0, 65535)), pick_byte());
   endtask

   // Drop valid and hold off until every reply is in
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // One operation: load operands, start, step it, read results back
   task automatic run_sequence();
      bit do_div;
      bit restart;
      int steps;
      int n_ticks;
      int restart_at;
      do_div = $urandom_range(0, 1);
      if (do_div) begin
         if ($urandom_range(0, 3) != 0) write_reg(ADDR_DIVD_LO, pick_byte());
         if ($urandom_range(0, 3) != 0) write_reg(ADDR_DIVD_HI, pick_byte());
         write_reg(ADDR_DIVISOR, pick_byte());
         steps = DIV_STEPS;
      end else begin
         if ($urandom_range(0, 3) != 0) write_reg(ADDR_MUL_A, pick_byte());
         write_reg(ADDR_MUL_B, pick_byte());
         steps = MUL_STEPS;
      end
      // mostly run to completion, sometimes stop early and leave it busy
      if ($urandom_range(0, 7) == 0) begin
         n_ticks = $urandom_range(0, steps - 1);
      end else begin
         n_ticks = steps + $urandom_range(0, 2);
      end
      restart    = ($urandom_range(0, 5) == 0);
      restart_at = $urandom_range(0, steps - 1);
      for (int i = 0; i < n_ticks; i++) begin
         if (restart && i == restart_at) begin
            write_reg($urandom_range(0, 1) ? ADDR_MUL_B : ADDR_DIVISOR, pick_byte());
         end
         if ($urandom_range(0, 5) == 0) begin
            send_beat(REQ_READ, result_addr($urandom_range(0, 3)), pick_byte());
         end
         run_ticks(1);
      end
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(0, 3) != 0) send_beat(REQ_READ, result_addr(i), pick_byte());
      end
   endtask

   // Stray access: any kind, at any address or, half of the time, near the register map
   task automatic send_noise();
      logic [15:0] addr;
      if ($urandom_range(0, 1)) begin
         addr = 16'($urandom_range(0, 65535));
      end else begin
         addr = 16'h4200 + 16'($urandom_range(0, 31));
      end
      send_beat(2'($urandom_range(0, 3)), addr, 8'($urandom_range(0, 255)));
   endtask

   // Check replies first, then note requests taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_reply(rsp_read_data, rsp_busy_res, rsp_bad_address);
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_type, req_address, req_write_data);
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Reply side: random stalls, and one long hold-off when asked
   initial begin
      int wait_cycles;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_replies) begin
            hold_replies = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            wait_cycles = draw_idle(recv_calm);
            if (wait_cycles > 0) begin
               rsp_ready <= 1'b0;
               repeat (wait_cycles) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      bit held;
      bit paused;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_TICK;
      req_address    = '0;
      req_write_data = '0;
      rsp_ready      = 1'b0;
      items_sent     = 0;
      send_calm      = 0;
      recv_calm      = 0;
      stall_cycles   = 0;
      hold_replies   = 1'b0;
      held           = 1'b0;
      paused         = 1'b0;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset value, idle tick, unknown request kind, unmapped accesses
      send_beat(REQ_READ, ADDR_PROD_HI, 8'h00);
      send_beat(REQ_TICK, 16'hFFFF, 8'hFF);
      send_beat(REQ_UNKNOWN, ADDR_MUL_B, 8'hFF);
      write_reg(16'hFFFF, 8'hAA);
      send_beat(REQ_READ, ADDR_MUL_A, 8'h00);
      write_reg(ADDR_QUOT_LO, 8'h55);

      // divide by zero, with multiply and divide starts landing while busy
      write_reg(ADDR_DIVD_LO, 8'hFF);
      write_reg(ADDR_DIVD_HI, 8'hFF);
      write_reg(ADDR_DIVISOR, 8'h00);
      run_ticks(4);
      write_reg(ADDR_MUL_B, 8'hFF);
      run_ticks(4);
      write_reg(ADDR_DIVISOR, 8'h01);
      run_ticks(8);
      send_beat(REQ_READ, ADDR_QUOT_HI, 8'h00);
      send_beat(REQ_READ, ADDR_PROD_HI, 8'h00);

      // random sequences mixed with stray accesses
      while (items_sent < ITEM_TARGET) begin
         if (!held && items_sent >= 400) begin
            held = 1'b1;
            hold_replies = 1'b1;
         end
         if (!paused && items_sent >= 900) begin
            paused = 1'b1;
            wait_drained();
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) send_noise();
         end else begin
            run_sequence();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
